@@ sv/lra_pkg.sv @@
// Shared types, constants and codes for the log record appender.
`default_nettype none

package lra_pkg;

    // Default build values
    localparam int HEADER_BYTES_DEF = 40;
    localparam int FIFO_DEPTH_DEF   = 4;

    // Port widths
    localparam int S_TDATA_W   = 240;
    localparam int M_TDATA_W   = 360;
    localparam int M_TUSER_W   = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    // Beat kinds carried on s_axis_tuser
    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_NUMBER   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_CAPACITY = 1'd1;

    localparam logic [31:0] CAPACITY_RESET = 32'd16777216;
    localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY       = 32'h82F6_3B78;

    // Result status codes
    typedef enum logic [1:0] {
        ST_HEADER_READY = 2'd0,
        ST_SEGMENT_FULL = 2'd1,
        ST_NO_RECORD    = 2'd2
    } status_t;

    // Classified command passed from front to back
    typedef struct packed {
        logic        op;
        logic        len_zero;
        logic [32:0] total;      // header bytes + payload length, unsaturated
        logic [7:0]  kind;
        logic [63:0] txn;
        logic [63:0] prev;
        logic [63:0] time_stamp;
        logic [7:0]  data_byte;
    } cmd_t;

endpackage

`default_nettype wire

@@ sv/lra_front.sv @@
// Front end: accepts input beats, unpacks and classifies them into commands.
`default_nettype none

module lra_front
    import lra_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // kind[7:0], txn[71:8], prev[135:72], length[167:136], time[231:168], byte[239:232]
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // operation[0]
    input  wire logic [0:0]           s_axis_tuser,
    input  wire logic                 fifo_full,
    output logic                      push,
    output cmd_t                      cmd
);

    logic [31:0] length;

    // Accept whenever the queue has room
    assign s_axis_tready = !fifo_full;
    assign push          = s_axis_tvalid && !fifo_full;

    // Unpack and precompute the record size
    always_comb begin
        length         = s_axis_tdata[167:136];
        cmd.op         = s_axis_tuser[0];
        cmd.kind       = s_axis_tdata[7:0];
        cmd.txn        = s_axis_tdata[71:8];
        cmd.prev       = s_axis_tdata[135:72];
        cmd.time_stamp = s_axis_tdata[231:168];
        cmd.data_byte  = s_axis_tdata[239:232];
        cmd.len_zero   = (length == 32'd0);
        cmd.total      = {1'b0, length} + 33'(HEADER_BYTES);
    end

endmodule

`default_nettype wire

@@ sv/lra_fifo.sv @@
// Short command queue between front and back end.
`default_nettype none

module lra_fifo
    import lra_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      pop_cmd,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");
`endif

endmodule

`default_nettype wire

@@ sv/lra_back.sv @@
// Back end: segment state, capacity check, CRC-32C and the result register.
`default_nettype none

module lra_back
    import lra_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   fifo_empty,
    input  wire cmd_t                   pop_cmd,
    output logic                        pop,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // seq[63:0], total[95:64], kind[103:96], txn[167:104], prev[231:168],
    // crc[263:232], time[327:264], start[359:328]
    output logic [M_TDATA_W-1:0]        m_axis_tdata,
    // status[1:0]
    output logic [M_TUSER_W-1:0]        m_axis_tuser,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    // One reflected CRC-32C byte step, unrolled
    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                                input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    // Configuration
    logic [31:0] segment_number_reg, segment_capacity_reg;

    // Segment and record state
    logic [31:0] write_offset_reg, write_offset_next;
    logic [31:0] running_crc_reg,  running_crc_next;
    logic [31:0] bytes_left_reg,   bytes_left_next;
    logic        record_open_reg,  record_open_next;
    logic [7:0]  held_kind_reg,    held_kind_next;
    logic [63:0] held_txn_reg,     held_txn_next;
    logic [63:0] held_prev_reg,    held_prev_next;
    logic [63:0] held_time_reg,    held_time_next;
    logic [31:0] held_start_reg,   held_start_next;
    logic [31:0] held_length_reg,  held_length_next;
    logic [31:0] held_segment_reg, held_segment_next;

    // Result register
    logic        m_valid_reg, m_valid_next;
    status_t     m_status_reg,  m_status_next;
    logic [31:0] m_segment_reg, m_segment_next;
    logic [31:0] m_start_reg,   m_start_next;
    logic [31:0] m_total_reg,   m_total_next;
    logic [7:0]  m_kind_reg,    m_kind_next;
    logic [63:0] m_txn_reg,     m_txn_next;
    logic [63:0] m_prev_reg,    m_prev_next;
    logic [31:0] m_crc_reg,     m_crc_next;
    logic [63:0] m_time_reg,    m_time_next;
    logic        emit;

    logic [31:0] total_sat;
    logic [33:0] end_sum;
    logic        refuse;
    logic [31:0] crc_new;

    // Take a command when the result slot is free or draining
    assign pop = !fifo_empty && (!m_valid_reg || m_axis_tready);

    // Datapath terms
    always_comb begin
        total_sat = pop_cmd.total[32] ? 32'hFFFF_FFFF : pop_cmd.total[31:0];
        end_sum   = {2'b00, write_offset_reg} + {1'b0, pop_cmd.total};
        refuse    = end_sum > {2'b00, segment_capacity_reg};
        crc_new   = crc32c_byte(running_crc_reg, pop_cmd.data_byte);
    end

    // Command execution
    always_comb begin
        write_offset_next = write_offset_reg;
        running_crc_next  = running_crc_reg;
        bytes_left_next   = bytes_left_reg;
        record_open_next  = record_open_reg;
        held_kind_next    = held_kind_reg;
        held_txn_next     = held_txn_reg;
        held_prev_next    = held_prev_reg;
        held_time_next    = held_time_reg;
        held_start_next   = held_start_reg;
        held_length_next  = held_length_reg;
        held_segment_next = held_segment_reg;
        emit              = 1'b0;
        m_status_next     = m_status_reg;
        m_segment_next    = m_segment_reg;
        m_start_next      = m_start_reg;
        m_total_next      = m_total_reg;
        m_kind_next       = m_kind_reg;
        m_txn_next        = m_txn_reg;
        m_prev_next       = m_prev_reg;
        m_crc_next        = m_crc_reg;
        m_time_next       = m_time_reg;

        if (pop) begin
            if (pop_cmd.op == OP_START) begin
                // A start drops any open record
                record_open_next = 1'b0;
                bytes_left_next  = 32'd0;
                running_crc_next = CRC_INIT;
                if (refuse || pop_cmd.len_zero) begin
                    emit           = 1'b1;
                    m_status_next  = refuse ? ST_SEGMENT_FULL : ST_HEADER_READY;
                    m_segment_next = segment_number_reg;
                    m_start_next   = write_offset_reg;
                    m_total_next   = total_sat;
                    m_kind_next    = pop_cmd.kind;
                    m_txn_next     = pop_cmd.txn;
                    m_prev_next    = pop_cmd.prev;
                    m_crc_next     = 32'd0;
                    m_time_next    = pop_cmd.time_stamp;
                    if (!refuse) begin
                        write_offset_next = write_offset_reg + total_sat;
                    end
                end else begin
                    record_open_next  = 1'b1;
                    bytes_left_next   = pop_cmd.total[31:0] - 32'(HEADER_BYTES);
                    held_kind_next    = pop_cmd.kind;
                    held_txn_next     = pop_cmd.txn;
                    held_prev_next    = pop_cmd.prev;
                    held_time_next    = pop_cmd.time_stamp;
                    held_start_next   = write_offset_reg;
                    held_length_next  = total_sat;
                    held_segment_next = segment_number_reg;
                end
            end else if (!record_open_reg) begin
                // Payload beat with no record open
                emit           = 1'b1;
                m_status_next  = ST_NO_RECORD;
                m_segment_next = 32'd0;
                m_start_next   = 32'd0;
                m_total_next   = 32'd0;
                m_kind_next    = 8'd0;
                m_txn_next     = 64'd0;
                m_prev_next    = 64'd0;
                m_crc_next     = 32'd0;
                m_time_next    = 64'd0;
            end else if (bytes_left_reg == 32'd1) begin
                // Last payload byte closes the record
                emit              = 1'b1;
                m_status_next     = ST_HEADER_READY;
                m_segment_next    = held_segment_reg;
                m_start_next      = held_start_reg;
                m_total_next      = held_length_reg;
                m_kind_next       = held_kind_reg;
                m_txn_next        = held_txn_reg;
                m_prev_next       = held_prev_reg;
                m_crc_next        = crc_new ^ CRC_INIT;
                m_time_next       = held_time_reg;
                write_offset_next = held_start_reg + held_length_reg;
                record_open_next  = 1'b0;
                bytes_left_next   = 32'd0;
                running_crc_next  = CRC_INIT;
            end else begin
                running_crc_next = crc_new;
                bytes_left_next  = bytes_left_reg - 32'd1;
            end
        end

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            segment_number_reg   <= 32'd0;
            segment_capacity_reg <= CAPACITY_RESET;
            write_offset_reg     <= 32'd0;
            running_crc_reg      <= CRC_INIT;
            bytes_left_reg       <= 32'd0;
            record_open_reg      <= 1'b0;
            m_valid_reg          <= 1'b0;
        end else begin
            if (cfg_wr_en && cfg_index == REG_SEGMENT_NUMBER) begin
                segment_number_reg <= cfg_wr_data;
            end
            if (cfg_wr_en && cfg_index == REG_SEGMENT_CAPACITY) begin
                segment_capacity_reg <= cfg_wr_data;
            end
            write_offset_reg <= write_offset_next;
            running_crc_reg  <= running_crc_next;
            bytes_left_reg   <= bytes_left_next;
            record_open_reg  <= record_open_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Held header and result payload
    always_ff @(posedge aclk) begin
        held_kind_reg    <= held_kind_next;
        held_txn_reg     <= held_txn_next;
        held_prev_reg    <= held_prev_next;
        held_time_reg    <= held_time_next;
        held_start_reg   <= held_start_next;
        held_length_reg  <= held_length_next;
        held_segment_reg <= held_segment_next;
        m_status_reg     <= m_status_next;
        m_segment_reg    <= m_segment_next;
        m_start_reg      <= m_start_next;
        m_total_reg      <= m_total_next;
        m_kind_reg       <= m_kind_next;
        m_txn_reg        <= m_txn_next;
        m_prev_reg       <= m_prev_next;
        m_crc_reg        <= m_crc_next;
        m_time_reg       <= m_time_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {m_start_reg, m_time_reg, m_crc_reg, m_prev_reg, m_txn_reg,
                            m_kind_reg, m_total_reg, m_segment_reg, m_start_reg};

`ifndef SYNTHESIS
    a_open_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        record_open_reg |-> bytes_left_reg != 32'd0)
        else $error("open record with no bytes left");
    a_idle_crc_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        !record_open_reg |-> running_crc_reg == CRC_INIT)
        else $error("crc not reseeded while no record open");
    a_refuse_keeps_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && pop_cmd.op == OP_START && refuse) |=> $stable(write_offset_reg))
        else $error("refused record moved the write offset");
    a_no_record_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == ST_NO_RECORD) |->
            (m_segment_reg == 32'd0 && m_start_reg == 32'd0 && m_crc_reg == 32'd0))
        else $error("stray payload result carries data");
`endif

endmodule

`default_nettype wire

@@ sv/log_record_append_crc32c.sv @@
// An input beat is registered in a queue entry and then in the result register on its way to its result beat.
// Throughput: one beat per cycle, start or payload byte, while the queue has room; the CRC-32C byte step is
//   unrolled in the back end and the capacity check is one 34-bit add and compare.
// A zero-length or refused start beat, the last payload byte and a stray payload byte give a result.
// Reset (aresetn, synchronous, active low) empties the queue, closes any record,
//   zeroes the write offset and loads the register defaults.
`default_nettype none

module log_record_append_crc32c
    import lra_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int FIFO_DEPTH   = FIFO_DEPTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // kind[7:0], txn[71:8], prev[135:72], length[167:136], time[231:168], byte[239:232]
    input  wire logic [S_TDATA_W-1:0]   s_axis_tdata,
    // operation[0]
    input  wire logic [0:0]             s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // seq[63:0], total[95:64], kind[103:96], txn[167:104], prev[231:168],
    // crc[263:232], time[327:264], start[359:328]
    output logic [M_TDATA_W-1:0]        m_axis_tdata,
    // status[1:0]
    output logic [M_TUSER_W-1:0]        m_axis_tuser,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    cmd_t push_cmd, pop_cmd;
    logic push, pop, fifo_full, fifo_empty;

    lra_front #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .fifo_full     (fifo_full),
        .push          (push),
        .cmd           (push_cmd)
    );

    lra_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    lra_back #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fifo_empty    (fifo_empty),
        .pop_cmd       (pop_cmd),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data)
    );

endmodule

`default_nettype wire

@@ test/tb_log_record_append_crc32c.sv @@
// Self-checking testbench for the log record appender with CRC-32C payload checksum.
module tb_log_record_append_crc32c
    import lra_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEADER_BYTES = HEADER_BYTES_DEF;
    localparam int LONG_HOLD    = 200;
    localparam int SETTLE_LEN   = 8;
    localparam int BLOCK_BEATS  = 30;

    // One input beat, split into its fields
    typedef struct {
        logic        op;
        logic [7:0]  kind;
        logic [63:0] txn;
        logic [63:0] prev;
        logic [31:0] len;
        logic [63:0] tstamp;
        logic [7:0]  data;
    } log_beat_t;

    // One result beat, split into its fields
    typedef struct {
        status_t     status;
        logic [63:0] seq;
        logic [31:0] total;
        logic [7:0]  kind;
        logic [63:0] txn;
        logic [63:0] prev;
        logic [31:0] crc;
        logic [63:0] tstamp;
        logic [31:0] start;
    } log_header_t;

    // Tracks the appender state and holds the headers still due on the result side
    class record_header_predictor;
        logic [31:0] segment_number;
        logic [31:0] capacity;
        logic [31:0] write_offset;
        logic [31:0] running_crc;
        logic [31:0] bytes_left;
        logic        record_open;
        log_header_t held;
        log_header_t expected_headers[$];
        int          errors;

        function new();
            segment_number = '0;
            capacity       = CAPACITY_RESET;
            write_offset   = '0;
            running_crc    = CRC_INIT;
            bytes_left     = '0;
            record_open    = 1'b0;
            held           = '{status: ST_HEADER_READY, default: '0};
            errors         = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] value);
            if (idx == REG_SEGMENT_NUMBER)
                segment_number = value;
            else
                capacity = value;
        endfunction

        function int pending();
            return expected_headers.size();
        endfunction

        function void queue_header(log_header_t h);
            expected_headers.insert(expected_headers.size(), h);
        endfunction

        function logic [31:0] crc32c_byte(logic [31:0] crc, logic [7:0] d);
            int k;
            crc = crc ^ {24'd0, d};
            for (k = 0; k < 8; k++)
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            return crc;
        endfunction

        function void note_beat(log_beat_t b);
            logic [32:0] total;
            logic [31:0] total32;
            log_header_t h;
            h = '{status: ST_HEADER_READY, default: '0};
            if (b.op == OP_START) begin
                total   = 33'(HEADER_BYTES) + {1'b0, b.len};
                total32 = total[32] ? 32'hFFFF_FFFF : total[31:0];
                // a new start always drops whatever record was open
                record_open = 1'b0;
                bytes_left  = '0;
                running_crc = CRC_INIT;
                h.seq    = {segment_number, write_offset};
                h.total  = total32;
                h.kind   = b.kind;
                h.txn    = b.txn;
                h.prev   = b.prev;
                h.tstamp = b.tstamp;
                h.start  = write_offset;
                if (34'(write_offset) + 34'(total) > 34'(capacity)) begin
                    h.status = ST_SEGMENT_FULL;
                    queue_header(h);
                end else if (b.len == 0) begin
                    h.status = ST_HEADER_READY;
                    queue_header(h);
                    write_offset = write_offset + total32;
                end else begin
                    h.status    = ST_HEADER_READY;
                    held        = h;
                    record_open = 1'b1;
                    bytes_left  = b.len;
                end
            end else if (!record_open) begin
                h.status = ST_NO_RECORD;
                queue_header(h);
            end else begin
                running_crc = crc32c_byte(running_crc, b.data);
                bytes_left  = bytes_left - 1;
                if (bytes_left == 0) begin
                    h     = held;
                    h.crc = running_crc ^ CRC_INIT;
                    queue_header(h);
                    write_offset = held.start + held.total;
                    record_open  = 1'b0;
                    running_crc  = CRC_INIT;
                end
            end
        endfunction

        function void match_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_header(logic [M_TUSER_W-1:0] user, logic [M_TDATA_W-1:0] data);
            log_header_t want;
            if (expected_headers.size() == 0) begin
                $error("result beat with no header expected: status %0d, seq 0x%0h",
                       user, data[63:0]);
                errors++;
                return;
            end
            want = expected_headers.pop_front();
            match_field("status",          want.status, user);
            match_field("sequence_number", want.seq,    data[63:0]);
            match_field("total_length",    want.total,  data[95:64]);
            match_field("header_kind",     want.kind,   data[103:96]);
            match_field("header_txn",      want.txn,    data[167:104]);
            match_field("header_previous", want.prev,   data[231:168]);
            match_field("payload_crc",     want.crc,    data[263:232]);
            match_field("header_time",     want.tstamp, data[327:264]);
            match_field("start_offset",    want.start,  data[359:328]);
        endfunction
    endclass

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [0:0]             s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [M_TUSER_W-1:0]   m_axis_tuser;
    logic                   cfg_wr_en     = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data   = '0;

    record_header_predictor headers = new();

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_requests      = 0;
    int hold_served        = 0;
    int hold_left          = 0;
    int beats_sent         = 0;

    log_record_append_crc32c i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side ready: long hold on request, random stalls otherwise
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served   <= hold_requests;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Bus monitor: check result beats, feed accepted input beats to the predictor
    always @(posedge aclk) begin
        log_beat_t seen;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready)
                headers.check_header(m_axis_tuser, m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) begin
                seen.op     = s_axis_tuser[0];
                seen.kind   = s_axis_tdata[7:0];
                seen.txn    = s_axis_tdata[71:8];
                seen.prev   = s_axis_tdata[135:72];
                seen.len    = s_axis_tdata[167:136];
                seen.tstamp = s_axis_tdata[231:168];
                seen.data   = s_axis_tdata[239:232];
                headers.note_beat(seen);
            end
        end
    end

    function automatic log_beat_t random_beat();
        log_beat_t b;
        b.op     = $urandom_range(0, 1);
        b.kind   = $urandom;
        b.txn    = {$urandom, $urandom};
        b.prev   = {$urandom, $urandom};
        b.len    = $urandom;
        b.tstamp = {$urandom, $urandom};
        b.data   = $urandom;
        return b;
    endfunction

    function automatic log_beat_t start_beat(logic [7:0] kind, logic [63:0] txn,
                                             logic [63:0] prev, logic [31:0] len,
                                             logic [63:0] tstamp);
        log_beat_t b;
        b        = random_beat();
        b.op     = OP_START;
        b.kind   = kind;
        b.txn    = txn;
        b.prev   = prev;
        b.len    = len;
        b.tstamp = tstamp;
        return b;
    endfunction

    function automatic log_beat_t byte_beat(logic [7:0] d);
        log_beat_t b;
        b      = random_beat();
        b.op   = OP_BYTE;
        b.data = d;
        return b;
    endfunction

    // Offer one beat, wait for the handshake, then maybe drop valid and idle
    task automatic send_beat(input log_beat_t b);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= b.op;
        s_axis_tdata  <= {b.data, b.tstamp, b.len, b.prev, b.txn, b.kind};
        do @(posedge aclk); while (!s_axis_tready);
        beats_sent++;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        headers.write_reg(idx, value);
    endtask

    task automatic write_regs(input logic [31:0] seg, input logic [31:0] cap);
        cfg_write(REG_SEGMENT_NUMBER, seg);
        cfg_write(REG_SEGMENT_CAPACITY, cap);
        cfg_wr_en <= 1'b0;
    endtask

    // Stop offering, drain every due header, then let the pipeline run dry
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (headers.pending() != 0) @(posedge aclk);
        repeat (SETTLE_LEN) @(posedge aclk);
    endtask

    task automatic send_bytes(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_beat(byte_beat($urandom));
    endtask

    // Mostly complete records with random content; some stray bytes and cut-short records
    task automatic random_record();
        log_beat_t   b;
        int unsigned pick;
        int unsigned len;
        int unsigned count;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            send_beat(byte_beat($urandom));
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 15)
            len = 0;
        else if (pick < 80)
            len = $urandom_range(1, 8);
        else if (pick < 95)
            len = $urandom_range(9, 64);
        else
            len = $urandom;
        b     = random_beat();
        b.op  = OP_START;
        b.len = len;
        send_beat(b);
        count = (len > 64) ? $urandom_range(0, 3) : len;
        if (count > 0 && $urandom_range(0, 99) < 6)
            count = $urandom_range(0, count - 1);
        send_bytes(count);
    endtask

    initial begin
        int          i;
        int          blk;
        int          block_end;
        logic [31:0] seg;
        logic [31:0] cap;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: stray bytes, an empty record, the standard check string, abandon, refusal
        send_beat(byte_beat(8'h00));
        send_beat(byte_beat(8'hFF));
        send_beat(start_beat(8'h00, '0, '0, 32'd0, '0));
        send_beat(start_beat(8'h5A, 64'h0123_4567_89AB_CDEF, 64'h1, 32'd9, 64'h77));
        for (i = 0; i < 9; i++)
            send_beat(byte_beat(8'h31 + 8'(i)));
        send_beat(start_beat(8'h11, 64'h2, 64'h3, 32'd3, 64'h4));
        send_beat(byte_beat(8'hFF));
        send_beat(start_beat(8'h22, 64'h5, 64'h6, 32'd2, 64'h7));
        send_bytes(2);
        send_beat(start_beat(8'hFF, '1, '1, 32'hFFFF_FFFF, '1));
        send_beat(byte_beat(8'h80));

        // Record that ends exactly at capacity, then one that does not fit
        settle();
        write_regs(32'hFFFF_FFFF, headers.write_offset + 32'(HEADER_BYTES) + 32'd2);
        send_beat(start_beat(8'h33, 64'h8, 64'h9, 32'd2, 64'hA));
        send_bytes(2);
        send_beat(start_beat(8'h44, 64'hB, 64'hC, 32'd0, 64'hD));

        // Segment number rewritten mid-record keeps the latched one
        settle();
        write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(start_beat(8'h55, 64'hE, 64'hF, 32'd5, 64'h10));
        send_bytes(1);
        settle();
        write_regs(32'hA5A5_5A5A, 32'hFFFF_FFFF);
        send_bytes(4);

        // Refused start drops the open record
        send_beat(start_beat(8'h66, 64'h11, 64'h12, 32'd4, 64'h13));
        send_bytes(1);
        send_beat(start_beat(8'h77, 64'h14, 64'h15, 32'hFFFF_FFF0, 64'h16));
        send_beat(byte_beat(8'h01));

        // Random part in blocks, each under its own register setting; the idling mix changes every four blocks
        for (blk = 0; blk < 12; blk++) begin
            settle();
            sender_idle_pct    = (blk < 4) ? 20 : (blk < 8) ? 76 : 0;
            receiver_stall_pct = (blk < 4) ? 76 : (blk < 8) ? 20 : 0;
            case ($urandom_range(0, 2))
                0:       seg = '0;
                1:       seg = '1;
                default: seg = $urandom;
            endcase
            case ($urandom_range(0, 5))
                0:       cap = '1;
                1:       cap = '0;
                2, 3:    cap = headers.write_offset + $urandom_range(0, 600);
                default: cap = $urandom;
            endcase
            write_regs(seg, cap);
            // long receiver stall while the sender pushes without gaps
            if (blk == 8)
                hold_requests = hold_requests + 1;
            block_end = beats_sent + BLOCK_BEATS;
            while (beats_sent < block_end)
                random_record();
        end

        settle();
        if (headers.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
